// File: sv/pls_pkg.sv
package pls_pkg;

    localparam int DEFAULT_DEPTH = 16;

    typedef enum logic [2:0] {
        REQ_ADD_FRONT  = 3'd0,
        REQ_ADD_END    = 3'd1,
        REQ_ADD_POS    = 3'd2,
        REQ_DROP_FRONT = 3'd3,
        REQ_DROP_END   = 3'd4,
        REQ_DROP_POS   = 3'd5
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic [4:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] count;
        logic       is_empty;
    } t_resp;

endpackage

// File: sv/positional_list_store.sv
// Bounded ordered list of up to DEPTH signed 32-bit values, entry 1 at the front, usable as a
// stack or a queue. Each request inserts at the front, the end or a 1-based position, or removes
// the front, the end or a position, and returns one response with status, count after the
// request and an empty flag; removed values are discarded. The entries sit in a row of cells,
// and the cells from the chosen position to the end all shift toward or away from it in the
// same cycle. A new request is taken every cycle while the output is not stalled; the response
// register accepts a new request in the same cycle that the previous response leaves, and a
// stalled response stalls the input. The response is registered on acceptance. Entry storage
// needs no clearing after reset.
module positional_list_store #(
    parameter int DEPTH = pls_pkg::DEFAULT_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  pls_pkg::t_req  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output pls_pkg::t_resp o_out_data,
    input  logic           i_out_stall
);
    import pls_pkg::*;

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5 ? CW : 5) + 1;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_resp         r_out_data;

    logic            accept;
    t_cell_op        cell_op;
    logic [IW-1:0]   cell_idx;
    t_status         status;
    logic            full;
    logic            empty;
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] pos_m1;
    logic [CMPW-1:0] cnt_m1;
    logic [CMPW-1:0] ncnt_x;

    logic signed [31:0] entry [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign cnt_x  = CMPW'(r_count);
    assign pos_x  = CMPW'(i_in_data.position);
    assign pos_m1 = pos_x - CMPW'(1);
    assign cnt_m1 = cnt_x - CMPW'(1);
    assign ncnt_x = CMPW'(n_count);

    always_comb begin
        cell_op  = CELL_HOLD;
        cell_idx = '0;
        status   = ST_OK;
        case (i_in_data.req_type)
            REQ_ADD_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cell_op = CELL_INS;
                end
            end
            REQ_ADD_END: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cell_op  = CELL_INS;
                    cell_idx = cnt_x[IW-1:0];
                end
            end
            REQ_ADD_POS: begin
                if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cell_op  = CELL_INS;
                    cell_idx = pos_m1[IW-1:0];
                end
            end
            REQ_DROP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    cell_op = CELL_DEL;
                end
            end
            REQ_DROP_END: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    cell_op  = CELL_DEL;
                    cell_idx = cnt_m1[IW-1:0];
                end
            end
            REQ_DROP_POS: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (pos_x == '0 || pos_x > cnt_x) begin
                    status = ST_RANGE;
                end else begin
                    cell_op  = CELL_DEL;
                    cell_idx = pos_m1[IW-1:0];
                end
            end
            default: begin
                cell_op = CELL_HOLD;
                status  = ST_OK;
            end
        endcase
        if (!accept) begin
            cell_op = CELL_HOLD;
        end
    end

    always_comb begin
        case (cell_op)
            CELL_INS: n_count = r_count + CW'(1);
            CELL_DEL: n_count = r_count - CW'(1);
            default:  n_count = r_count;
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] left;
        logic signed [31:0] right;
        if (g == 0) begin : g_first
            assign left = i_in_data.value;
        end else begin : g_mid_l
            assign left = entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right = entry[g];
        end else begin : g_mid_r
            assign right = entry[g+1];
        end
        pls_cell #(
            .DEPTH(DEPTH),
            .INDEX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_idx   (cell_idx),
            .i_value (i_in_data.value),
            .i_left  (left),
            .i_right (right),
            .o_entry (entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data.status   <= status;
            r_out_data.count    <= ncnt_x[4:0];
            r_out_data.is_empty <= (n_count == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: sv/pls_cell.sv
module pls_cell #(
    parameter int DEPTH = pls_pkg::DEFAULT_DEPTH,
    parameter int INDEX = 0
) (
    input  logic                     i_clk,
    input  pls_pkg::t_cell_op        i_op,
    input  logic [$clog2(DEPTH)-1:0] i_idx,
    input  logic signed [31:0]       i_value,
    input  logic signed [31:0]       i_left,
    input  logic signed [31:0]       i_right,
    output logic signed [31:0]       o_entry
);
    import pls_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_op)
            CELL_INS: begin
                if (MY_IDX == i_idx) begin
                    n_entry = i_value;
                end else if (MY_IDX > i_idx) begin
                    n_entry = i_left;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= i_idx) begin
                    n_entry = i_right;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: sim/pls_response_checker.sv
`timescale 1ns / 100ps

module pls_response_checker #(
    parameter int DEPTH = pls_pkg::DEFAULT_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  pls_pkg::t_req  i_in_data,
    input  logic           i_in_stall,
    input  logic           i_out_valid,
    input  pls_pkg::t_resp i_out_data,
    input  logic           i_out_stall,
    output int             o_fail_count,
    output int             o_pending
);
    import pls_pkg::*;

    logic signed [31:0] list_vals [DEPTH];
    int unsigned        list_len;
    t_resp              expected_resps [$];
    t_resp              want;

    task automatic note_mismatch(input string field, input int got, input int exp);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, exp, $realtime);
        o_fail_count++;
    endtask

    // idx is 0-based, idx <= list_len < DEPTH
    function automatic void insert_at(input int unsigned idx, input logic signed [31:0] v);
        for (int unsigned i = list_len; i > idx; i--) begin
            list_vals[i] = list_vals[i - 1];
        end
        list_vals[idx] = v;
        list_len++;
    endfunction

    // idx is 0-based, idx < list_len
    function automatic void remove_at(input int unsigned idx);
        for (int unsigned i = idx; i + 1 < list_len; i++) begin
            list_vals[i] = list_vals[i + 1];
        end
        list_len--;
    endfunction

    function automatic t_resp apply_request(input t_req r);
        t_resp       rsp;
        t_status     st;
        int unsigned p;
        st = ST_OK;
        p  = r.position;
        case (r.req_type)
            REQ_ADD_FRONT: begin
                if (list_len >= DEPTH) st = ST_FULL;
                else insert_at(0, r.value);
            end
            REQ_ADD_END: begin
                if (list_len >= DEPTH) st = ST_FULL;
                else insert_at(list_len, r.value);
            end
            REQ_ADD_POS: begin
                if (p < 1 || p > list_len + 1) st = ST_RANGE;
                else if (list_len >= DEPTH) st = ST_FULL;
                else insert_at(p - 1, r.value);
            end
            REQ_DROP_FRONT: begin
                if (list_len == 0) st = ST_EMPTY;
                else remove_at(0);
            end
            REQ_DROP_END: begin
                if (list_len == 0) st = ST_EMPTY;
                else remove_at(list_len - 1);
            end
            REQ_DROP_POS: begin
                if (list_len == 0) st = ST_EMPTY;
                else if (p < 1 || p > list_len) st = ST_RANGE;
                else remove_at(p - 1);
            end
            default: ;
        endcase
        rsp.status   = st;
        rsp.count    = list_len[4:0];
        rsp.is_empty = (list_len == 0);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            expected_resps.delete();
        end else begin
            // the response is registered, so compare before taking the new item
            if (i_out_valid && !i_out_stall) begin
                if (expected_resps.size() == 0) begin
                    note_mismatch("unexpected item, status", int'(i_out_data.status), -1);
                end else begin
                    want = expected_resps.pop_front();
                    if (i_out_data.status !== want.status)
                        note_mismatch("status", int'(i_out_data.status), int'(want.status));
                    if (i_out_data.count !== want.count)
                        note_mismatch("count", int'(i_out_data.count), int'(want.count));
                    if (i_out_data.is_empty !== want.is_empty)
                        note_mismatch("is_empty", int'(i_out_data.is_empty),
                                      int'(want.is_empty));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_resps.push_back(apply_request(i_in_data));
            end
        end
        o_pending <= expected_resps.size();
    end

endmodule

// File: sim/tb_positional_list_store.sv
`timescale 1ns / 100ps

module tb_positional_list_store;
    import pls_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASE_ITEMS = 135;
    localparam int         SEG_ITEMS   = 28;
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    typedef enum int {MIX_FILL, MIX_ANY, MIX_DRAIN} t_mix;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    t_req  i_in_data;
    logic  o_in_stall;
    logic  o_out_valid;
    t_resp o_out_data;
    logic  i_out_stall = 1'b0;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;

    positional_list_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    pls_response_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_in_stall   (o_in_stall),
        .i_out_valid  (o_out_valid),
        .i_out_data   (o_out_data),
        .i_out_stall  (i_out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_req make_req(input logic [2:0] kind, input logic [31:0] v,
                                      input logic [4:0] pos);
        t_req r;
        r.req_type = kind;
        r.value    = v;
        r.position = pos;
        return r;
    endfunction

    function automatic t_req random_req(input t_mix mix);
        t_req r;
        int   pick;
        r.value    = $urandom();
        r.position = 5'($urandom_range(31));
        pick       = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                if (pick < 40) r.req_type = REQ_ADD_FRONT;
                else if (pick < 80) r.req_type = REQ_ADD_END;
                else begin
                    r.req_type = REQ_ADD_POS;
                    r.position = 5'($urandom_range(17));
                end
            end
            MIX_DRAIN: begin
                if (pick < 30) r.req_type = REQ_DROP_FRONT;
                else if (pick < 60) r.req_type = REQ_DROP_END;
                else begin
                    r.req_type = REQ_DROP_POS;
                    r.position = 5'($urandom_range(17));
                end
            end
            default: begin
                r.req_type = 3'($urandom_range(7));
                if (pick < 70) r.position = 5'($urandom_range(17));
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input t_req item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    initial begin
        t_mix mix;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        send_idle_pct  = 8;
        recv_stall_pct = 59;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list, range checks, one-entry drop end, unknown requests
        send_item(make_req(REQ_DROP_FRONT, 32'h0, 5'd0));
        send_item(make_req(REQ_DROP_END, 32'h0, 5'd0));
        send_item(make_req(REQ_DROP_POS, 32'h0, 5'd0));
        send_item(make_req(REQ_ADD_POS, 32'h1234_5678, 5'd0));
        send_item(make_req(REQ_ADD_POS, 32'h1234_5678, 5'd2));
        send_item(make_req(REQ_ADD_POS, 32'h7FFF_FFFF, 5'd1));
        send_item(make_req(REQ_DROP_END, 32'hFFFF_FFFF, 5'd31));
        send_item(make_req(REQ_ADD_FRONT, 32'h8000_0000, 5'd31));
        send_item(make_req(REQ_ADD_END, 32'h7FFF_FFFF, 5'd0));
        send_item(make_req(REQ_ADD_POS, 32'hFFFF_FFFF, 5'd3));
        send_item(make_req(REQ_ADD_POS, 32'h0, 5'd31));
        send_item(make_req(REQ_DROP_POS, 32'h0, 5'd0));
        send_item(make_req(REQ_DROP_POS, 32'h0, 5'd4));
        send_item(make_req(REQ_DROP_POS, 32'h0, 5'd2));
        send_item(make_req(REQ_SPARE_6, 32'hFFFF_FFFF, 5'd31));
        send_item(make_req(REQ_SPARE_7, 32'h0, 5'd1));
        send_item(make_req(REQ_DROP_FRONT, 32'h0, 5'd0));
        send_item(make_req(REQ_DROP_END, 32'h0, 5'd0));

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 59;
                end
                1: begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 8;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ((n / SEG_ITEMS) % 4)
                    0: mix = MIX_FILL;
                    2: mix = MIX_DRAIN;
                    default: mix = MIX_ANY;
                endcase
                send_item(random_req(mix));
            end
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
